>>> rtl/u8u2_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
`timescale 1ns / 1ps

package u8u2_pkg;

    // Status codes of a result
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ST_BAD_CONT  = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    // Byte class bounds
    localparam logic [7:0] ASCII_MAX  = 8'h7f;
    localparam logic [7:0] CONT_MAX   = 8'hbf;
    localparam logic [7:0] LEAD_LIMIT = 8'hfd;
    localparam logic [7:0] LEAD3_MIN  = 8'he0;
    localparam logic [7:0] LEAD4_MIN  = 8'hf0;
    localparam logic [7:0] LEAD5_MIN  = 8'hf8;
    localparam logic [7:0] LEAD6_MIN  = 8'hfc;

    // Code point bounds
    localparam logic [15:0] SURR_LOW  = 16'hd7ff;
    localparam logic [15:0] SURR_HIGH = 16'hdfff;
    localparam logic [15:0] CODE_MAX  = 16'hfffd;
    localparam logic [15:0] MIN_2BYTE = 16'h0080;
    localparam logic [15:0] MIN_3BYTE = 16'h0800;

    // Sequence lengths
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;
    localparam logic [2:0] LEN_5 = 3'd5;
    localparam logic [2:0] LEN_6 = 3'd6;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } byte_item_t;

    // Result item
    typedef struct packed {
        logic [15:0] code_point;
        logic [2:0]  status;
        logic        last_of_string;
    } char_item_t;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [2:0]  pending_count;
        logic [2:0]  sequence_length;
        logic [15:0] accumulator;
    } dec_state_t;

endpackage

>>> rtl/u8u2_step.sv
// Combinational decode of one byte against the current sequence state.
`timescale 1ns / 1ps

module u8u2_step
    import u8u2_pkg::*;
(
    input  dec_state_t cur_state,
    input  byte_item_t item,
    output dec_state_t next_state,
    output logic       emit,
    output char_item_t result
);

    logic [7:0]  b;
    logic        eos;
    logic [15:0] acc_shift;
    logic [2:0]  pend_dec;
    logic        cp_bad;

    assign b         = item.data_byte;
    assign eos       = item.end_of_string;
    assign acc_shift = {cur_state.accumulator[9:0], b[5:0]};
    assign pend_dec  = cur_state.pending_count - 3'd1;

    // Validity of a completed sequence
    always_comb
    begin
        cp_bad = 1'b0;
        if (cur_state.sequence_length >= LEN_4)
            cp_bad = 1'b1;
        else if (acc_shift > SURR_LOW && acc_shift <= SURR_HIGH)
            cp_bad = 1'b1;
        else if (acc_shift > CODE_MAX)
            cp_bad = 1'b1;
        else if (cur_state.sequence_length == LEN_2 && acc_shift < MIN_2BYTE)
            cp_bad = 1'b1;
        else if (cur_state.sequence_length == LEN_3 && acc_shift < MIN_3BYTE)
            cp_bad = 1'b1;
    end

    // Next state and result
    always_comb
    begin
        next_state            = '0;
        emit                  = 1'b0;
        result.code_point     = '0;
        result.status         = ST_OK;
        result.last_of_string = eos;
        if (cur_state.pending_count == 3'd0)
        begin
            // awaiting a lead byte
            if (b <= ASCII_MAX)
            begin
                emit              = 1'b1;
                result.code_point = {8'h00, b};
            end
            else if (b <= CONT_MAX || b >= LEAD_LIMIT)
            begin
                emit          = 1'b1;
                result.status = ST_BAD_LEAD;
            end
            else if (eos)
            begin
                emit          = 1'b1;
                result.status = ST_TRUNCATED;
            end
            else
            begin
                if (b < LEAD3_MIN)
                begin
                    next_state.sequence_length = LEN_2;
                    next_state.accumulator     = {11'd0, b[4:0]};
                end
                else if (b < LEAD4_MIN)
                begin
                    next_state.sequence_length = LEN_3;
                    next_state.accumulator     = {12'd0, b[3:0]};
                end
                else if (b < LEAD5_MIN)
                begin
                    next_state.sequence_length = LEN_4;
                    next_state.accumulator     = {13'd0, b[2:0]};
                end
                else if (b < LEAD6_MIN)
                begin
                    next_state.sequence_length = LEN_5;
                    next_state.accumulator     = {14'd0, b[1:0]};
                end
                else
                begin
                    next_state.sequence_length = LEN_6;
                    next_state.accumulator     = {15'd0, b[0]};
                end
                next_state.pending_count = next_state.sequence_length - 3'd1;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            // not a continuation byte: drop the sequence and the byte
            emit          = 1'b1;
            result.status = ST_BAD_CONT;
        end
        else if (pend_dec != 3'd0)
        begin
            // more continuation bytes to come
            if (eos)
            begin
                emit          = 1'b1;
                result.status = ST_TRUNCATED;
            end
            else
            begin
                next_state.pending_count   = pend_dec;
                next_state.sequence_length = cur_state.sequence_length;
                next_state.accumulator     = acc_shift;
            end
        end
        else
        begin
            // sequence complete
            emit = 1'b1;
            if (cp_bad)
                result.status = ST_INVALID;
            else
                result.code_point = acc_shift;
        end
    end

endmodule

>>> rtl/utf8_to_ucs2_decoder_top.sv
// Top level of the UTF-8 to UCS-2 stream decoder.
`timescale 1ns / 1ps
//
// Usage
//   byte channel (byte_valid/byte_ready/byte_data): one UTF-8 byte per transfer,
//   with end_of_string set on the last byte of a string.
//   char channel (char_valid/char_ready/char_data): one UCS-2 code point with a
//   status per transfer. Multi-byte leads and inner continuation bytes give no
//   transfer unless marked end_of_string; every byte so marked gives exactly one.
// Timing
//   A byte is held in an input register, decoded by one level of compare and
//   shift logic, and the result lands in the output register, from which it
//   transfers when the receiver is ready.
//   Throughput is one byte per cycle while char_ready keeps the output free,
//   set by the single decode stage.
// Reset
//   rst_n clears both stage valids and the sequence state (awaiting a lead).
// Stall
//   While char_ready is low a waiting result holds; one more byte is taken
//   into the input register if it is empty, after which byte_ready falls.
//
module utf8_to_ucs2_decoder_top
    import u8u2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_data,
    output logic       char_valid,
    input  logic       char_ready,
    output char_item_t char_data
);

    logic       in_valid_reg;
    byte_item_t in_item_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    logic       out_valid_reg;
    char_item_t out_item_reg;
    logic       step_emit;
    char_item_t step_result;
    logic       out_free;
    logic       stage_fire;

    // Handshake between the stages
    assign out_free   = !out_valid_reg || char_ready;
    assign stage_fire = in_valid_reg && out_free;
    assign byte_ready = !in_valid_reg || stage_fire;

    u8u2_step u_step (
        .cur_state  (state_reg),
        .item       (in_item_reg),
        .next_state (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_ready)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            in_item_reg <= byte_data;
    end

    // Sequence state, advanced as each byte is decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (stage_fire)
            state_reg <= state_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= stage_fire && step_emit;
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && step_emit)
            out_item_reg <= step_result;
    end

    assign char_valid = out_valid_reg;
    assign char_data  = out_item_reg;

endmodule

>>> rtl/u8u2_checker.sv
// Port-level checks on the UTF-8 to UCS-2 decoder, bound to the top level.
`timescale 1ns / 1ps

module u8u2_checker
    import u8u2_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       byte_ready,
    input logic       char_valid,
    input logic       char_ready,
    input char_item_t char_data
);

    // A stalled result holds
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(char_data))
        else $error("result changed while stalled");

    // With no result waiting the byte channel is always open
    a_byte_open: assert property (@(posedge clk) disable iff (!rst_n)
        !char_valid |-> byte_ready)
        else $error("byte channel closed with no result waiting");

    // Status stays within the defined codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> char_data.status <= ST_TRUNCATED)
        else $error("status out of range");

    // Error results carry a zero code point
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_data.status != ST_OK |-> char_data.code_point == 16'd0)
        else $error("error result with non-zero code point");

    // Truncation is only reported on the last byte of a string
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_data.status == ST_TRUNCATED |-> char_data.last_of_string)
        else $error("truncation without end of string");

endmodule

bind utf8_to_ucs2_decoder_top u8u2_checker u_u8u2_checker (.*);
